/* hdl/acsw_pkg.sv */
package acsw_pkg;

  localparam int SAMPLE_WIDTH_DEF = 24;

  localparam int FRAC = 28;
  localparam int CORDIC_STEPS = 26;
  localparam int CW = 40;
  localparam int ZW = 32;

  localparam logic signed [CW-1:0] ONE_Q = 40'sd268435456;
  localparam logic signed [CW-1:0] GAIN_Q = 40'sd163008219;

  localparam logic [31:0] PI_Q = 32'd843314857;
  localparam logic [31:0] HALF_PI_Q = 32'd421657428;
  localparam logic [31:0] TWO_PI_Q = 32'd1686629713;
  localparam logic signed [31:0] TWO_OVER_PI_Q = 32'sd170891319;
  localparam logic signed [31:0] INV_1P3_Q = 32'sd206488812;

  // Argument magnitude before the divide by 100 that lands on the Q8.16 limit.
  localparam logic [29:0] ARG_QMAX = 30'd838860799;
  // ceil(2^37 / 100)
  localparam logic [30:0] RECIP_100 = 31'd1374389535;
  // 21 turns of 2*pi, lifts every argument above zero.
  localparam logic [36:0] RED_OFFSET = 37'd35419223973;
  // floor(2^44 / (2*pi in Q28))
  localparam logic [13:0] RECIP_2PI = 14'd10430;
  // ceil(2^31 / 1000) and ceil(2^40 / 1000)
  localparam logic [21:0] RECIP_1000_HI = 22'd2147484;
  localparam logic [30:0] RECIP_1000_LO = 31'd1099511628;
  localparam logic [9:0] THOUSAND = 10'd1000;

  localparam int CFG_IW = 2;
  localparam int CFG_DW = 7;
  localparam logic [CFG_IW-1:0] REG_DRIVE = 2'd0;
  localparam logic [CFG_IW-1:0] REG_RANGE = 2'd1;
  localparam logic [CFG_IW-1:0] REG_MIX = 2'd2;
  localparam logic [CFG_IW-1:0] REG_VOLUME = 2'd3;

  typedef struct packed {
    logic [CFG_DW-1:0] drive_tenths;
    logic [CFG_DW-1:0] range_tenths;
    logic [CFG_DW-1:0] mix_tenths;
    logic [CFG_DW-1:0] volume_hundredths;
    logic [2*CFG_DW-1:0] drive_range;
  } cfg_t;

  function automatic logic signed [ZW-1:0] step_angle(input int unsigned i);
    logic signed [ZW-1:0] a;
    unique case (i)
      0: a = 32'sd210828714;
      1: a = 32'sd124459457;
      2: a = 32'sd65760959;
      3: a = 32'sd33381290;
      4: a = 32'sd16755422;
      5: a = 32'sd8385879;
      6: a = 32'sd4193963;
      7: a = 32'sd2097109;
      8: a = 32'sd1048571;
      9: a = 32'sd524287;
      default: a = ZW'(64'd1 << (FRAC - i));
    endcase
    return a;
  endfunction

endpackage

/* hdl/acsw_front.sv */
module acsw_front import acsw_pkg::*; #(
  parameter int SW = SAMPLE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [SW-1:0] sample,
  input  cfg_t                 cfg,
  output logic                 out_valid,
  output logic signed [35:0]   yq,
  output logic [29:0]          angle,
  output logic                 neg,
  output logic signed [SW-1:0] x_out
);

  localparam int NS = 11;

  logic [NS:1] vld;
  logic signed [SW-1:0] xr [1:NS];

  logic signed [SW+14:0] p1;
  logic [SW+14:0] mag;
  logic [SW+15:0] shv;
  logic [29:0] q2;
  logic sgn2, sgn3, sgn4;
  logic [60:0] prod3;
  logic [22:0] yabs;
  logic signed [23:0] y4;
  logic signed [35:0] yq4, yq5, yq6, yq7, yq8, yq9, yq10;
  logic [36:0] u4, u5, u6;
  logic [30:0] prod5;
  logic [36:0] qm;
  logic [31:0] rem;
  logic [30:0] m8;
  logic [29:0] m9, m10;
  logic neg10;

  assign mag = p1[SW+14] ? $unsigned(-p1) : $unsigned(p1);

  generate
    if (SW >= 17) begin : g_down
      assign shv = {1'b0, mag} >> (SW - 17);
    end else begin : g_up
      assign shv = {mag, 1'b0};
    end
  endgenerate

  assign y4 = sgn4 ? -$signed({1'b0, yabs}) : $signed({1'b0, yabs});

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[NS-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr[1] <= sample;
      for (int i = 2; i <= NS; i++) begin
        xr[i] <= xr[i-1];
      end
      p1 <= sample * $signed({1'b0, cfg.drive_range});
      q2 <= (shv[29:0] > ARG_QMAX) ? ARG_QMAX : shv[29:0];
      sgn2 <= p1[SW+14];
      prod3 <= q2 * RECIP_100;
      sgn3 <= sgn2;
      yabs <= prod3[59:37];
      sgn4 <= sgn3;
      yq4 <= {y4, 12'b0};
      u4 <= $unsigned(37'(signed'({y4, 12'b0}))) + RED_OFFSET;
      prod5 <= u4[36:20] * RECIP_2PI;
      yq5 <= yq4;
      u5 <= u4;
      qm <= prod5[29:24] * TWO_PI_Q[30:0];
      yq6 <= yq5;
      u6 <= u5;
      rem <= 32'(u6 - qm);
      yq7 <= yq6;
      // Remainder estimate is at most one turn high.
      m8 <= (rem >= TWO_PI_Q) ? 31'(rem - TWO_PI_Q) : rem[30:0];
      yq8 <= yq7;
      m9 <= ({1'b0, m8} > PI_Q) ? 30'(TWO_PI_Q[30:0] - m8) : m8[29:0];
      yq9 <= yq8;
      if ({2'b0, m9} > HALF_PI_Q) begin
        m10 <= 30'(PI_Q[29:0] - m9);
        neg10 <= 1'b1;
      end else begin
        m10 <= m9;
        neg10 <= 1'b0;
      end
      yq10 <= yq9;
    end
  end

  assign out_valid = vld[NS];
  assign yq = yq10;
  assign angle = m10;
  assign neg = neg10;
  assign x_out = xr[NS];

endmodule

/* hdl/acsw_cordic.sv */
module acsw_cordic import acsw_pkg::*; #(
  parameter bit VECTORING = 1'b0,
  parameter int SIDE_W = 1
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] x_in,
  input  logic signed [CW-1:0] y_in,
  input  logic signed [ZW-1:0] z_in,
  input  logic [SIDE_W-1:0]    side_in,
  output logic                 out_valid,
  output logic signed [CW-1:0] x_out,
  output logic signed [CW-1:0] y_out,
  output logic signed [ZW-1:0] z_out,
  output logic [SIDE_W-1:0]    side_out
);

  logic signed [CW-1:0] xs [0:CORDIC_STEPS];
  logic signed [CW-1:0] ys [0:CORDIC_STEPS];
  logic signed [ZW-1:0] zs [0:CORDIC_STEPS];
  logic [SIDE_W-1:0] ss [0:CORDIC_STEPS];
  logic vs [0:CORDIC_STEPS];

  assign xs[0] = x_in;
  assign ys[0] = y_in;
  assign zs[0] = z_in;
  assign ss[0] = side_in;
  assign vs[0] = in_valid;

  generate
    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_step
      localparam logic signed [ZW-1:0] ANG = step_angle(i);
      logic signed [CW-1:0] dx, dy;
      logic up;

      assign dx = ys[i] >>> i;
      assign dy = xs[i] >>> i;
      // Vectoring drives y to zero, rotation drives z to zero.
      if (VECTORING) begin : g_vec
        assign up = ys[i] > 0;
      end else begin : g_rot
        assign up = zs[i] < 0;
      end

      always_ff @(posedge clk) begin
        if (rst) begin
          vs[i+1] <= 1'b0;
        end else if (en) begin
          vs[i+1] <= vs[i];
        end
      end

      always_ff @(posedge clk) begin
        if (en) begin
          ss[i+1] <= ss[i];
          if (up) begin
            xs[i+1] <= xs[i] + dx;
            ys[i+1] <= ys[i] - dy;
            zs[i+1] <= zs[i] + ANG;
          end else begin
            xs[i+1] <= xs[i] - dx;
            ys[i+1] <= ys[i] + dy;
            zs[i+1] <= zs[i] - ANG;
          end
        end
      end
    end
  endgenerate

  assign out_valid = vs[CORDIC_STEPS];
  assign x_out = xs[CORDIC_STEPS];
  assign y_out = ys[CORDIC_STEPS];
  assign z_out = zs[CORDIC_STEPS];
  assign side_out = ss[CORDIC_STEPS];

endmodule

/* hdl/acsw_shape.sv */
module acsw_shape import acsw_pkg::*; #(
  parameter int SW = SAMPLE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [ZW-1:0] atan_z,
  input  logic signed [CW-1:0] cos_x,
  input  logic                 neg,
  input  logic signed [SW-1:0] x_in,
  output logic                 out_valid,
  output logic signed [ZW-1:0] v,
  output logic signed [SW-1:0] x_out
);

  logic [3:1] vld;
  logic signed [SW-1:0] xr [1:3];
  logic signed [63:0] pa;
  logic signed [CW-1:0] ch;
  logic signed [31:0] ct;
  logic signed [32:0] s;
  logic signed [63:0] pv;

  assign ch = cos_x >>> 1;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[2:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      xr[1] <= x_in;
      xr[2] <= xr[1];
      xr[3] <= xr[2];
      pa <= atan_z * TWO_OVER_PI_Q;
      ct <= neg ? 32'(-ch) : 32'(ch);
      s <= 33'($signed(pa[59:28])) + 33'(ct);
      pv <= s * INV_1P3_Q;
    end
  end

  assign out_valid = vld[3];
  assign v = pv[59:28];
  assign x_out = xr[3];

endmodule

/* hdl/acsw_mix.sv */
module acsw_mix import acsw_pkg::*; #(
  parameter int SW = SAMPLE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic signed [CW-1:0] wet,
  input  logic signed [SW-1:0] x_in,
  input  cfg_t                 cfg,
  output logic                 out_valid,
  output logic [SW-1:0]        sample,
  output logic                 clip
);

  localparam logic [40:0] A_MAX = 41'(64'd1000 * ((64'd1 << (SW - 1)) + 64'd1));
  localparam logic [32:0] HI = 33'((64'd1 << (SW - 1)) - 64'd1);
  localparam logic [32:0] LIM = 33'(64'd1 << (SW - 1));

  logic [7:1] vld;
  logic signed [31:0] clean;
  logic signed [7:0] cw;
  logic signed [39:0] pw, pc;
  logic signed [40:0] mixed;
  logic signed [48:0] num;
  logic [47:0] mag;
  logic [50:0] shv;
  logic [40:0] a;
  logic [20:0] ah6;
  logic [19:0] al6;
  logic [42:0] p6;
  logic [11:0] q1_7, q1_8;
  logic [29:0] a7;
  logic [60:0] p8;
  logic [31:0] q;
  logic neg4, neg5, neg6, neg7;

  generate
    if (SW <= 29) begin : g_up
      assign clean = 32'(x_in) <<< (29 - SW);
      assign shv = {3'b0, mag} >> (29 - SW);
    end else begin : g_down
      assign clean = 32'(x_in >>> (SW - 29));
      assign shv = {3'b0, mag} << (SW - 29);
    end
  endgenerate

  assign cw = 8'sd10 - $signed({1'b0, cfg.mix_tenths});
  assign mag = num[48] ? 48'(-num) : 48'(num);
  assign q = {q1_8, p8[59:40]};

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[6:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      pw <= 32'(wet) * $signed({1'b0, cfg.mix_tenths});
      pc <= clean * cw;
      mixed <= 41'(pw) + 41'(pc);
      num <= mixed * $signed({1'b0, cfg.volume_hundredths});
      neg4 <= num[48];
      // Anything at or above the clamp saturates either way.
      a <= (shv > 51'(A_MAX)) ? A_MAX : shv[40:0];
      neg5 <= neg4;
      // Divide by 1000 in two digits: high 21 bits, then remainder with low 20.
      p6 <= a[40:20] * RECIP_1000_HI;
      ah6 <= a[40:20];
      al6 <= a[19:0];
      neg6 <= neg5;
      a7 <= {10'(ah6 - 21'(p6[42:31] * THOUSAND)), al6};
      q1_7 <= p6[42:31];
      neg7 <= neg6;
      p8 <= a7 * RECIP_1000_LO;
      q1_8 <= q1_7;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= vld[7];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (!neg7) begin
        if ({1'b0, q} > HI) begin
          sample <= HI[SW-1:0];
          clip <= 1'b1;
        end else begin
          sample <= q[SW-1:0];
          clip <= 1'b0;
        end
      end else begin
        if ({1'b0, q} > LIM) begin
          sample <= LIM[SW-1:0];
          clip <= 1'b1;
        end else begin
          sample <= SW'(32'(-q));
          clip <= 1'b0;
        end
      end
    end
  end

endmodule

/* hdl/arctan_cosine_sine_waveshaper_top.sv */
// Throughput: one sample per cycle while the output is not stalled; the front, the three
// 26-stage CORDIC pipelines and the mix and divide stages each take a new item every
// cycle unless the output is stalled.
// A stalled output holds the whole pipeline in place; nothing is lost or repeated.
// Synchronous active-high reset clears all valid bits and loads the register defaults.
module arctan_cosine_sine_waveshaper_top import acsw_pkg::*; #(
  parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] sample_in,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] sample_out,
  output logic                           clipped,
  input  logic                           cfg_we,
  input  logic [CFG_IW-1:0]              cfg_index,
  input  logic [CFG_DW-1:0]              cfg_data
);

  localparam int SW = SAMPLE_WIDTH;

  cfg_t cfg;
  logic en;

  logic f_valid, f_neg;
  logic signed [35:0] f_yq;
  logic [29:0] f_angle;
  logic signed [SW-1:0] f_x;

  logic a_valid, c_valid;
  logic signed [ZW-1:0] a_z;
  logic a_neg;
  logic signed [CW-1:0] c_x;
  logic signed [SW-1:0] c_side;

  logic s_valid;
  logic signed [ZW-1:0] s_v;
  logic signed [SW-1:0] s_x;

  logic w_valid;
  logic signed [CW-1:0] w_y;
  logic signed [SW-1:0] w_x;

  logic [SW-1:0] m_sample;

  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.drive_tenths <= 7'd10;
      cfg.range_tenths <= 7'd10;
      cfg.mix_tenths <= 7'd10;
      cfg.volume_hundredths <= 7'd50;
      cfg.drive_range <= 14'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DRIVE: begin
          cfg.drive_tenths <= cfg_data;
          cfg.drive_range <= cfg_data * cfg.range_tenths;
        end
        REG_RANGE: begin
          cfg.range_tenths <= cfg_data;
          cfg.drive_range <= cfg.drive_tenths * cfg_data;
        end
        REG_MIX: begin
          cfg.mix_tenths <= cfg_data;
        end
        REG_VOLUME: begin
          cfg.volume_hundredths <= cfg_data;
        end
        default: begin
        end
      endcase
    end
  end

  acsw_front #(.SW(SW)) u_front (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(in_valid), .sample(sample_in), .cfg(cfg),
    .out_valid(f_valid), .yq(f_yq), .angle(f_angle), .neg(f_neg), .x_out(f_x)
  );

  acsw_cordic #(.VECTORING(1'b1), .SIDE_W(1)) u_atan (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid),
    .x_in(ONE_Q), .y_in(CW'(f_yq)), .z_in('0), .side_in(f_neg),
    .out_valid(a_valid), .x_out(), .y_out(), .z_out(a_z), .side_out(a_neg)
  );

  acsw_cordic #(.VECTORING(1'b0), .SIDE_W(SW)) u_cos (
    .clk(clk), .rst(rst), .en(en), .in_valid(f_valid),
    .x_in(GAIN_Q), .y_in('0), .z_in(ZW'(f_angle)), .side_in(f_x),
    .out_valid(c_valid), .x_out(c_x), .y_out(), .z_out(), .side_out(c_side)
  );

  acsw_shape #(.SW(SW)) u_shape (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(a_valid & c_valid), .atan_z(a_z), .cos_x(c_x), .neg(a_neg),
    .x_in(c_side),
    .out_valid(s_valid), .v(s_v), .x_out(s_x)
  );

  acsw_cordic #(.VECTORING(1'b0), .SIDE_W(SW)) u_sin (
    .clk(clk), .rst(rst), .en(en), .in_valid(s_valid),
    .x_in(GAIN_Q), .y_in('0), .z_in(s_v), .side_in(s_x),
    .out_valid(w_valid), .x_out(), .y_out(w_y), .z_out(), .side_out(w_x)
  );

  acsw_mix #(.SW(SW)) u_mix (
    .clk(clk), .rst(rst), .en(en),
    .in_valid(w_valid), .wet(w_y), .x_in(w_x), .cfg(cfg),
    .out_valid(out_valid), .sample(m_sample), .clip(clipped)
  );

  assign sample_out = $signed(m_sample);

endmodule
